### rtl/pbud_pkg.sv
// Shared types, constants and helpers for the protobuf user record decoder.
// Used by every module of the decoder; no dependencies.
`default_nettype none
package pbud_pkg;

	localparam int unsigned ID_CAP         = 16;
	localparam int unsigned LONG_NAME_CAP  = 40;
	localparam int unsigned SHORT_NAME_CAP = 5;
	localparam int unsigned MAX_MSG_LEN    = 1024;

	localparam int unsigned LEN_W            = 11;
	localparam int unsigned POS_W            = 6;
	localparam int unsigned NRES             = 3;
	localparam int unsigned ACC_W            = 35;
	localparam int unsigned VARINT_DIGIT_W   = 7;
	localparam int unsigned VARINT_MAX_BYTES = 10;

	localparam logic [7:0] CHAR_LO  = 8'h20;
	localparam logic [7:0] CHAR_HI  = 8'h7E;
	localparam logic [6:0] CHAR_SUB = 7'h2E;

	localparam int unsigned SLOT_CHAR    = 0;
	localparam int unsigned SLOT_NAMEEND = 1;
	localparam int unsigned SLOT_SUMMARY = 2;

	typedef enum logic [1:0] {
		KIND_CHAR     = 2'd0,
		KIND_NAME_END = 2'd1,
		KIND_SUMMARY  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		SEL_ID    = 2'd0,
		SEL_LONG  = 2'd1,
		SEL_SHORT = 2'd2
	} name_sel_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
		logic       end_only;
	} in_item_t;

	typedef struct packed {
		kind_t             kind;
		name_sel_t         name_select;
		logic [POS_W-1:0]  position;
		logic [6:0]        char_value;
		logic [31:0]       model_num;
		logic              has_long;
		logic              has_short;
		logic              ok;
	} result_t;

	typedef struct packed {
		logic [NRES-1:0]          mask;
		result_t [NRES-1:0]       slot;
	} result_set_t;

	function automatic logic [POS_W-1:0] name_limit(input name_sel_t sel);
		logic [POS_W-1:0] lim;
		case (sel)
			SEL_ID:    lim = POS_W'(ID_CAP - 1);
			SEL_LONG:  lim = POS_W'(LONG_NAME_CAP - 1);
			SEL_SHORT: lim = POS_W'(SHORT_NAME_CAP - 1);
			default:   lim = POS_W'(SHORT_NAME_CAP - 1);
		endcase
		return lim;
	endfunction

endpackage
`default_nettype wire

### rtl/pbud_in_stage.sv
// Input register of the decoder: captures one byte item per transfer.
// Depends on pbud_pkg.
`default_nettype none
module pbud_in_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         data_byte,
	input  wire logic               is_last,
	input  wire logic               end_only,
	input  wire logic               advance,
	output logic                    valid_s1,
	output pbud_pkg::in_item_t      item_s1
);

	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1.data_byte <= data_byte;
			item_s1.is_last   <= is_last;
			item_s1.end_only  <= end_only;
		end
	end

endmodule
`default_nettype wire

### rtl/pbud_decode.sv
// Wire-format decode state and next-state logic; builds up to three results per item.
// Depends on pbud_pkg.
`default_nettype none
module pbud_decode (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pbud_pkg::in_item_t   item,
	input  wire logic                 advance,
	output pbud_pkg::result_set_t     set
);

	typedef enum logic [2:0] {
		PH_TAG   = 3'd0,
		PH_VALUE = 3'd1,
		PH_SIZE  = 3'd2,
		PH_SKIP  = 3'd3,
		PH_NAME  = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		FLD_OTHER = 3'd0,
		FLD_ID    = 3'd1,
		FLD_LONG  = 3'd2,
		FLD_SHORT = 3'd3,
		FLD_MODEL = 3'd4
	} fld_t;

	localparam int unsigned ACC_W = pbud_pkg::ACC_W;
	localparam int unsigned LEN_W = pbud_pkg::LEN_W;
	localparam int unsigned POS_W = pbud_pkg::POS_W;

	phase_t             phase_q, phase_d;
	logic [ACC_W-1:0]   acc_q, acc_d, acc_n;
	logic               hi_q, hi_d, hi_n;
	logic [3:0]         vb_q, vb_d;
	fld_t               fld_q, fld_d, fld_new;
	logic [LEN_W-1:0]   left_q, left_d;
	logic [POS_W-1:0]   cc_q, cc_d;
	logic [31:0]        model_q, model_d;
	logic               long_q, long_d;
	logic               short_q, short_d;
	logic               err_q, err_d;

	logic [5:0]         sh;
	logic [63:0]        shifted;
	logic [31:0]        fld_num;
	logic               too_big;
	logic               is_name;
	pbud_pkg::name_sel_t sel;
	logic [7:0]         b;

	always_comb begin
		case (fld_q)
			FLD_ID:    sel = pbud_pkg::SEL_ID;
			FLD_LONG:  sel = pbud_pkg::SEL_LONG;
			FLD_SHORT: sel = pbud_pkg::SEL_SHORT;
			default:   sel = pbud_pkg::SEL_ID;
		endcase
	end

	assign is_name = (fld_q == FLD_ID) || (fld_q == FLD_LONG) || (fld_q == FLD_SHORT);
	assign b       = item.data_byte;
	assign sh      = 6'(vb_q) * 6'(pbud_pkg::VARINT_DIGIT_W);
	assign shifted = {57'd0, b[6:0]} << sh;
	assign acc_n   = acc_q | shifted[ACC_W-1:0];
	assign hi_n    = hi_q | (|shifted[63:ACC_W]);
	assign fld_num = acc_n[ACC_W-1:3];
	assign too_big = hi_n || (|acc_n[ACC_W-1:LEN_W])
		|| (acc_n[LEN_W-1:0] > LEN_W'(pbud_pkg::MAX_MSG_LEN));

	always_comb begin
		case (fld_num)
			32'd1:   fld_new = FLD_ID;
			32'd2:   fld_new = FLD_LONG;
			32'd3:   fld_new = FLD_SHORT;
			32'd5:   fld_new = FLD_MODEL;
			default: fld_new = FLD_OTHER;
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		hi_d    = hi_q;
		vb_d    = vb_q;
		fld_d   = fld_q;
		left_d  = left_q;
		cc_d    = cc_q;
		model_d = model_q;
		long_d  = long_q;
		short_d = short_q;
		err_d   = err_q;
		set     = '0;

		if (!item.end_only && !err_q) begin
			case (phase_q)
				PH_SKIP: begin
					left_d = left_q - LEN_W'(1);
					if (left_d == '0) begin
						phase_d = PH_TAG;
					end
				end
				PH_NAME: begin
					if (cc_q < pbud_pkg::name_limit(sel)) begin
						set.mask[pbud_pkg::SLOT_CHAR]             = 1'b1;
						set.slot[pbud_pkg::SLOT_CHAR].kind        = pbud_pkg::KIND_CHAR;
						set.slot[pbud_pkg::SLOT_CHAR].name_select = sel;
						set.slot[pbud_pkg::SLOT_CHAR].position    = cc_q;
						set.slot[pbud_pkg::SLOT_CHAR].char_value  =
							(b >= pbud_pkg::CHAR_LO && b <= pbud_pkg::CHAR_HI)
							? b[6:0] : pbud_pkg::CHAR_SUB;
						cc_d = cc_q + POS_W'(1);
					end
					left_d = left_q - LEN_W'(1);
					if (left_d == '0) begin
						set.mask[pbud_pkg::SLOT_NAMEEND]             = 1'b1;
						set.slot[pbud_pkg::SLOT_NAMEEND].kind        = pbud_pkg::KIND_NAME_END;
						set.slot[pbud_pkg::SLOT_NAMEEND].name_select = sel;
						set.slot[pbud_pkg::SLOT_NAMEEND].position    = cc_d;
						cc_d    = '0;
						phase_d = PH_TAG;
					end
				end
				default: begin
					if (vb_q >= 4'(pbud_pkg::VARINT_MAX_BYTES)) begin
						err_d = 1'b1;
					end else begin
						acc_d = acc_n;
						hi_d  = hi_n;
						vb_d  = vb_q + 4'd1;
						if (!b[7]) begin
							acc_d   = '0;
							hi_d    = 1'b0;
							vb_d    = '0;
							phase_d = PH_TAG;
							case (phase_q)
								PH_TAG: begin
									fld_d = fld_new;
									if (fld_num == '0) begin
										err_d = 1'b1;
									end else begin
										case (acc_n[2:0])
											3'd0: phase_d = PH_VALUE;
											3'd2: phase_d = PH_SIZE;
											3'd1: begin
												left_d  = LEN_W'(8);
												phase_d = PH_SKIP;
											end
											3'd5: begin
												left_d  = LEN_W'(4);
												phase_d = PH_SKIP;
											end
											default: err_d = 1'b1;
										endcase
									end
								end
								PH_VALUE: begin
									if (fld_q == FLD_MODEL) begin
										model_d = acc_n[31:0];
									end
								end
								default: begin
									if (too_big) begin
										err_d = 1'b1;
									end else if (is_name) begin
										if (fld_q == FLD_LONG) begin
											long_d = |acc_n[LEN_W-1:0];
										end
										if (fld_q == FLD_SHORT) begin
											short_d = |acc_n[LEN_W-1:0];
										end
										cc_d = '0;
										if (acc_n[LEN_W-1:0] == '0) begin
											set.mask[pbud_pkg::SLOT_NAMEEND]      = 1'b1;
											set.slot[pbud_pkg::SLOT_NAMEEND].kind =
												pbud_pkg::KIND_NAME_END;
											set.slot[pbud_pkg::SLOT_NAMEEND].name_select = sel;
										end else begin
											left_d  = acc_n[LEN_W-1:0];
											phase_d = PH_NAME;
										end
									end else if (acc_n[LEN_W-1:0] != '0) begin
										left_d  = acc_n[LEN_W-1:0];
										phase_d = PH_SKIP;
									end
								end
							endcase
						end
					end
				end
			endcase
		end

		if (item.is_last || item.end_only) begin
			set.mask[pbud_pkg::SLOT_SUMMARY]           = 1'b1;
			set.slot[pbud_pkg::SLOT_SUMMARY].kind      = pbud_pkg::KIND_SUMMARY;
			set.slot[pbud_pkg::SLOT_SUMMARY].model_num = model_d;
			set.slot[pbud_pkg::SLOT_SUMMARY].has_long  = long_d;
			set.slot[pbud_pkg::SLOT_SUMMARY].has_short = short_d;
			set.slot[pbud_pkg::SLOT_SUMMARY].ok        =
				!err_d && (phase_d == PH_TAG) && (vb_d == '0);
			phase_d = PH_TAG;
			acc_d   = '0;
			hi_d    = 1'b0;
			vb_d    = '0;
			fld_d   = FLD_OTHER;
			left_d  = '0;
			cc_d    = '0;
			model_d = '0;
			long_d  = 1'b0;
			short_d = 1'b0;
			err_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			acc_q   <= '0;
			hi_q    <= 1'b0;
			vb_q    <= '0;
			fld_q   <= FLD_OTHER;
			left_q  <= '0;
			cc_q    <= '0;
			model_q <= '0;
			long_q  <= 1'b0;
			short_q <= 1'b0;
			err_q   <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			hi_q    <= hi_d;
			vb_q    <= vb_d;
			fld_q   <= fld_d;
			left_q  <= left_d;
			cc_q    <= cc_d;
			model_q <= model_d;
			long_q  <= long_d;
			short_q <= short_d;
			err_q   <= err_d;
		end
	end

endmodule
`default_nettype wire

### rtl/pbud_out_buf.sv
// Result register: holds the results of one item and drains them one per transfer.
// Depends on pbud_pkg.
`default_nettype none
module pbud_out_buf (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire pbud_pkg::result_set_t set,
	output logic                       can_load,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output pbud_pkg::result_t          res,
	output logic                       run_last
);

	localparam int unsigned NRES = pbud_pkg::NRES;

	logic [NRES-1:0]              mask_q;
	pbud_pkg::result_t [NRES-1:0] slot_q;
	logic [NRES-1:0]              pick;
	logic [NRES-1:0]              rest;
	logic                         take;

	assign pick      = mask_q & (~mask_q + NRES'(1));
	assign rest      = mask_q & ~pick;
	assign out_valid = |mask_q;
	assign run_last  = (rest == '0);
	assign take      = out_valid && !out_stall;
	assign can_load  = (mask_q == '0) || (take && run_last);

	always_comb begin
		res = '0;
		for (int i = 0; i < NRES; i++) begin
			if (pick[i]) begin
				res = slot_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= set.mask;
		end else if (take) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= set.slot;
		end
	end

endmodule
`default_nettype wire

### rtl/protobuf_user_record_decoder_top.sv
// Top level of the protobuf user record decoder: input register, decode, result register.
// Depends on pbud_pkg, pbud_in_stage, pbud_decode and pbud_out_buf.
//
//   channel | handshake                  | payload
//   in      | in_valid / in_stall        | data_byte, is_last, end_only
//   out     | out_valid / out_stall      | kind .. ok, run_last
//
// One byte item enters per cycle while in_stall is low; an item that makes results holds
// the input until earlier results have drained, one result per transfer.
// Items that make no result pass even while results drain.
// Items pass the input register, the decode logic and the result register in that order.
// Reset (arst_n low) clears the decode state and empties both registers.
`default_nettype none
module protobuf_user_record_decoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        is_last,
	input  wire logic        end_only,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [1:0]       name_select,
	output logic [5:0]       position,
	output logic [6:0]       char_value,
	output logic [31:0]      model_num,
	output logic             has_long,
	output logic             has_short,
	output logic             ok,
	output logic             run_last
);

	logic                  valid_s1;
	pbud_pkg::in_item_t    item_s1;
	pbud_pkg::result_set_t set;
	pbud_pkg::result_t     res;
	logic                  can_load;
	logic                  advance;
	logic                  load;

	assign advance = valid_s1 && ((set.mask == '0) || can_load);
	assign load    = advance && (set.mask != '0);

	pbud_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.is_last   (is_last),
		.end_only  (end_only),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	pbud_decode u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.advance (advance),
		.set     (set)
	);

	pbud_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.set       (set),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res),
		.run_last  (run_last)
	);

	assign kind        = res.kind;
	assign name_select = res.name_select;
	assign position    = res.position;
	assign char_value  = res.char_value;
	assign model_num   = res.model_num;
	assign has_long    = res.has_long;
	assign has_short   = res.has_short;
	assign ok          = res.ok;

endmodule
`default_nettype wire

### dv/protobuf_user_record_decoder_top_tb.sv
// Self-checking testbench for protobuf_user_record_decoder_top: byte-stream records in,
// an in-bench wire-format decoder predicts every result, each result compared in order.
// Depends on pbud_pkg and the decoder RTL.
module protobuf_user_record_decoder_top_tb;
	import pbud_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned RANDOM_ITEMS   = 125;

	typedef enum logic [2:0] {
		PH_TAG   = 3'd0,
		PH_VALUE = 3'd1,
		PH_SIZE  = 3'd2,
		PH_SKIP  = 3'd3,
		PH_NAME  = 3'd4
	} dec_phase_t;

	typedef struct packed {
		result_t res;
		logic    run_last;
	} dec_result_t;

	typedef struct packed {
		in_item_t item;
		logic     drain;
	} stim_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        is_last = 1'b0;
	logic        end_only = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [1:0]  name_select;
	logic [5:0]  position;
	logic [6:0]  char_value;
	logic [31:0] model_num;
	logic        has_long;
	logic        has_short;
	logic        ok;
	logic        run_last;

	// decoder state mirror
	dec_phase_t  dec_phase;
	logic [63:0] vacc;
	logic [3:0]  vcount;
	logic [31:0] fnum;
	logic [10:0] remain;
	logic [5:0]  ccount;
	logic [31:0] model;
	logic        long_seen;
	logic        short_seen;
	logic        err_seen;

	dec_result_t pending_results[$];
	stim_t       stim_q[$];
	logic [7:0]  rec[$];

	stim_t       cur_item;
	dec_result_t want;
	int unsigned in_gap, in_calm, out_gap, out_calm, hold_cnt, idle_cycles;
	int unsigned n_items, n_results, n_records, mismatches;
	int unsigned n_chars, n_ends, n_summaries, n_clean;
	bit          held;

	protobuf_user_record_decoder_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.is_last    (is_last),
		.end_only   (end_only),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.name_select(name_select),
		.position   (position),
		.char_value (char_value),
		.model_num  (model_num),
		.has_long   (has_long),
		.has_short  (has_short),
		.ok         (ok),
		.run_last   (run_last)
	);

	function automatic void restart_tag();
		vacc = '0;
		vcount = '0;
		dec_phase = PH_TAG;
	endfunction

	function automatic void clear_decoder();
		restart_tag();
		fnum = '0;
		remain = '0;
		ccount = '0;
		model = '0;
		long_seen = 1'b0;
		short_seen = 1'b0;
		err_seen = 1'b0;
	endfunction

	function automatic result_t mk_result(kind_t k, name_sel_t s, logic [5:0] p, logic [6:0] c);
		result_t r;
		r = '0;
		r.kind = k;
		r.name_select = s;
		r.position = p;
		r.char_value = c;
		return r;
	endfunction

	task automatic decode_item(input in_item_t it);
		result_t     batch[$];
		result_t     r;
		dec_result_t e;
		logic [7:0]  b;
		logic [63:0] sz;
		logic [31:0] f;
		logic [2:0]  wtype;
		logic [5:0]  lim;
		logic [6:0]  ch;
		name_sel_t   sel;
		b = it.data_byte;
		if (!it.end_only && !err_seen) begin
			case (dec_phase)
				PH_SKIP: begin
					remain = remain - 11'd1;
					if (remain == '0)
						restart_tag();
				end
				PH_NAME: begin
					sel = name_sel_t'(fnum[1:0] - 2'd1);
					case (sel)
						SEL_ID:   lim = 6'(ID_CAP - 1);
						SEL_LONG: lim = 6'(LONG_NAME_CAP - 1);
						default:  lim = 6'(SHORT_NAME_CAP - 1);
					endcase
					if (ccount < lim) begin
						ch = (b >= CHAR_LO && b <= CHAR_HI) ? b[6:0] : CHAR_SUB;
						batch.push_back(mk_result(KIND_CHAR, sel, ccount, ch));
						ccount = ccount + 6'd1;
					end
					remain = remain - 11'd1;
					if (remain == '0) begin
						batch.push_back(mk_result(KIND_NAME_END, sel, ccount, 7'd0));
						ccount = '0;
						restart_tag();
					end
				end
				default: begin
					if (vcount >= 4'd10) begin
						err_seen = 1'b1;
					end else begin
						vacc = vacc | (64'(b[6:0]) << (7 * vcount));
						vcount = vcount + 4'd1;
						if (!b[7]) begin
							case (dec_phase)
								PH_TAG: begin
									f = vacc[34:3];
									wtype = vacc[2:0];
									fnum = f;
									restart_tag();
									if (f == '0) begin
										err_seen = 1'b1;
									end else if (wtype == 3'd0) begin
										dec_phase = PH_VALUE;
									end else if (wtype == 3'd2) begin
										dec_phase = PH_SIZE;
									end else if (wtype == 3'd1) begin
										remain = 11'd8;
										dec_phase = PH_SKIP;
									end else if (wtype == 3'd5) begin
										remain = 11'd4;
										dec_phase = PH_SKIP;
									end else begin
										err_seen = 1'b1;
									end
								end
								PH_VALUE: begin
									if (fnum == 32'd5)
										model = vacc[31:0];
									restart_tag();
								end
								default: begin
									sz = vacc;
									restart_tag();
									if (sz > 64'(MAX_MSG_LEN)) begin
										err_seen = 1'b1;
									end else if (fnum >= 32'd1 && fnum <= 32'd3) begin
										if (fnum == 32'd2)
											long_seen = (sz != '0);
										if (fnum == 32'd3)
											short_seen = (sz != '0);
										ccount = '0;
										if (sz == '0) begin
											batch.push_back(mk_result(KIND_NAME_END,
												name_sel_t'(fnum[1:0] - 2'd1), 6'd0, 7'd0));
										end else begin
											remain = sz[10:0];
											dec_phase = PH_NAME;
										end
									end else if (sz != '0) begin
										remain = sz[10:0];
										dec_phase = PH_SKIP;
									end
								end
							endcase
						end
					end
				end
			endcase
		end
		if (it.is_last || it.end_only) begin
			r = mk_result(KIND_SUMMARY, SEL_ID, 6'd0, 7'd0);
			r.model_num = model;
			r.has_long = long_seen;
			r.has_short = short_seen;
			r.ok = !err_seen && dec_phase == PH_TAG && vcount == '0;
			batch.push_back(r);
			clear_decoder();
		end
		foreach (batch[i]) begin
			e.res = batch[i];
			e.run_last = (i == batch.size() - 1);
			pending_results.push_back(e);
		end
	endtask

	function automatic int unsigned draw_wait(inout int unsigned calm);
		if (calm != 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			calm = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 15);
	endfunction

	task automatic put_item(input logic [7:0] b, input logic last, input logic endo,
			input logic drain);
		stim_t s;
		s.item.data_byte = b;
		s.item.is_last = last;
		s.item.end_only = endo;
		s.drain = drain;
		stim_q.push_back(s);
	endtask

	task automatic add_varint(input logic [63:0] v, input int unsigned extra);
		logic [7:0]  bq[$];
		logic [63:0] rest;
		rest = v;
		do begin
			bq.push_back({1'b1, rest[6:0]});
			rest = rest >> 7;
		end while (rest != '0);
		repeat (extra) bq.push_back(8'h80);
		bq[bq.size() - 1][7] = 1'b0;
		foreach (bq[i]) rec.push_back(bq[i]);
	endtask

	task automatic add_tag(input logic [31:0] f, input logic [2:0] wt);
		add_varint(64'({f, wt}), 0);
	endtask

	function automatic int unsigned pick_len(int unsigned cap);
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(cap - 2, cap + 1);
		return $urandom_range(0, 6);
	endfunction

	task automatic add_name(input logic [31:0] f, input int unsigned len);
		add_tag(f, 3'd2);
		add_varint(64'(len), ($urandom_range(0, 5) == 0) ? 1 : 0);
		repeat (len)
			rec.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(32, 126)));
	endtask

	task automatic add_model();
		add_tag(32'd5, 3'd0);
		case ($urandom_range(0, 4))
			0: begin
				repeat (9) rec.push_back(8'hFF);
				rec.push_back(8'h7F);
			end
			1: add_varint(64'hFFFF_FFFF, 0);
			2: add_varint({$urandom, $urandom}, 0);
			default: add_varint(64'($urandom), ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
		endcase
	endtask

	task automatic add_other();
		logic [31:0] f;
		logic [2:0]  wt;
		int unsigned n;
		case ($urandom_range(0, 3))
			0: f = 32'($urandom_range(1, 3));
			1: f = 32'($urandom_range(4, 15));
			2: f = 32'd5;
			default: f = $urandom;
		endcase
		if (f == '0)
			f = 32'd1;
		case ($urandom_range(0, 3))
			0: wt = 3'd0;
			1: wt = 3'd1;
			2: wt = 3'd2;
			default: wt = 3'd5;
		endcase
		add_tag(f, wt);
		if (wt == 3'd0) begin
			add_varint({$urandom, $urandom} >> $urandom_range(0, 63), 0);
		end else begin
			n = (wt == 3'd1) ? 8 : (wt == 3'd5) ? 4 : $urandom_range(0, 6);
			if (wt == 3'd2)
				add_varint(64'(n), 0);
			repeat (n) rec.push_back(8'($urandom));
		end
	endtask

	task automatic add_broken();
		int unsigned w;
		case ($urandom_range(0, 4))
			0: repeat ($urandom_range(1, 6)) rec.push_back(8'($urandom));
			1: add_varint((($urandom_range(0, 1) != 0) ? (64'h1 << 35) : 64'h0)
				| 64'($urandom_range(0, 7)), 0);
			2: begin
				w = $urandom_range(0, 3);
				add_tag(32'($urandom_range(1, 20)), 3'((w < 2) ? 3 + w : 4 + w));
			end
			3: begin
				add_tag(32'd5, 3'd0);
				repeat (10) rec.push_back(8'h80);
				rec.push_back(8'h01);
			end
			default: begin
				add_tag(32'($urandom_range(1, 6)), 3'd2);
				add_varint(64'(MAX_MSG_LEN + 1) + 64'($urandom_range(0, 5000)), 0);
			end
		endcase
	endtask

	task automatic flush_record(input bit use_end, input bit drain);
		bit ends;
		ends = use_end || rec.size() == 0;
		foreach (rec[i])
			put_item(rec[i], !ends && i == rec.size() - 1, 1'b0, drain && i == 0);
		if (ends)
			put_item(8'($urandom), 1'($urandom), 1'b1, drain && rec.size() == 0);
		rec = {};
		n_records++;
	endtask

	task automatic gen_record(input bit drain);
		int unsigned shape;
		shape = $urandom_range(0, 99);
		repeat ($urandom_range(0, 4)) begin
			case ($urandom_range(0, 5))
				0: add_name(32'd1, pick_len(ID_CAP));
				1: add_name(32'd2, pick_len(LONG_NAME_CAP));
				2: add_name(32'd3, pick_len(SHORT_NAME_CAP));
				3: add_model();
				default: add_other();
			endcase
		end
		if (shape < 15 && rec.size() > 1) begin
			repeat ($urandom_range(1, rec.size() - 1)) void'(rec.pop_back());
		end else if (shape < 30) begin
			add_broken();
			if ($urandom_range(0, 1) != 0)
				add_other();
		end
		flush_record($urandom_range(0, 3) == 0, drain);
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'h00;
			is_last <= 1'b0;
			end_only <= 1'b0;
			in_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				decode_item(cur_item.item);
				n_items++;
				in_gap = draw_wait(in_calm);
			end
			if (!(in_valid && in_stall)) begin
				if (in_gap != 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (stim_q.size() != 0 && (!stim_q[0].drain
						|| (pending_results.size() == 0 && !out_valid))) begin
					cur_item = stim_q.pop_front();
					in_valid <= 1'b1;
					data_byte <= cur_item.item.data_byte;
					is_last <= cur_item.item.is_last;
					end_only <= cur_item.item.end_only;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string nm, input logic [31:0] exp_v, input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, nm, exp_v, act_v);
			mismatches++;
		end
	endtask

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap = 0;
			hold_cnt = 0;
		end else begin
			if (out_valid && !out_stall) begin
				n_results++;
				case (kind_t'(kind))
					KIND_CHAR:     n_chars++;
					KIND_NAME_END: n_ends++;
					default: begin
						n_summaries++;
						if (ok)
							n_clean++;
					end
				endcase
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, expected none actual kind %0d", $time, kind);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("kind", 32'(want.res.kind), 32'(kind));
					check_field("name_select", 32'(want.res.name_select), 32'(name_select));
					check_field("position", 32'(want.res.position), 32'(position));
					check_field("char_value", 32'(want.res.char_value), 32'(char_value));
					check_field("model_num", want.res.model_num, model_num);
					check_field("has_long", 32'(want.res.has_long), 32'(has_long));
					check_field("has_short", 32'(want.res.has_short), 32'(has_short));
					check_field("ok", 32'(want.res.ok), 32'(ok));
					check_field("run_last", 32'(want.run_last), 32'(run_last));
				end
			end
			if (hold_cnt != 0) begin
				hold_cnt--;
				out_stall <= (hold_cnt != 0);
			end else if (out_valid && !out_stall) begin
				if (!held && n_results >= 40) begin
					held = 1'b1;
					hold_cnt = HOLD_CYCLES;
					out_stall <= 1'b1;
				end else begin
					out_gap = draw_wait(out_calm);
					out_stall <= (out_gap != 0);
				end
			end else if (out_gap != 0) begin
				out_gap--;
				out_stall <= (out_gap != 0);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else if (arst_n) begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		int unsigned target;
		clear_decoder();

		put_item(8'h5A, 1'b1, 1'b1, 1'b0);
		rec = {8'h1A, 8'h06, 8'h00, 8'h20, 8'h7E, 8'h7F, 8'hFF, 8'h41, 8'h12, 8'h00};
		flush_record(1'b1, 1'b0);
		rec = {8'h00, 8'h0A};
		flush_record(1'b0, 1'b0);
		rec = {8'h0B};
		flush_record(1'b0, 1'b0);
		rec = {8'h0A, 8'h81, 8'h08};
		flush_record(1'b0, 1'b0);
		rec = {8'h0A, 8'h01, 8'h78};
		flush_record(1'b0, 1'b0);
		rec = {8'h28};
		flush_record(1'b0, 1'b0);

		target = stim_q.size() + RANDOM_ITEMS;
		gen_record(1'b1);
		while (stim_q.size() < target)
			gen_record($urandom_range(0, 9) == 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || in_valid)
			@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Covered %0d records in %0d byte items, long receiver hold %s", n_records,
			n_items, held ? "done" : "not reached");
		$display("Results: %0d name chars, %0d name ends, %0d summaries (%0d clean), %0d mismatches",
			n_chars, n_ends, n_summaries, n_clean, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0t: %0d expected results never arrived", $time, pending_results.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### sim.f
rtl/pbud_pkg.sv
rtl/pbud_in_stage.sv
rtl/pbud_decode.sv
rtl/pbud_out_buf.sv
rtl/protobuf_user_record_decoder_top.sv
dv/protobuf_user_record_decoder_top_tb.sv
